/* rtl/core/dsched_pkg.sv */
// Shared types, codes and helpers for the disk request scheduler.
package dsched_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int SLOT_IDX_W = 8;
  localparam int CYL_W      = 16;
  localparam int TOTAL_W    = 32;
  localparam int TRAVEL_W   = CYL_W + 2;

  localparam logic [CYL_W-1:0] MAX_CYL_RESET = 16'd9999;

  localparam logic [1:0] MODE_FCFS  = 2'd0;
  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_CSCAN = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_MAX   = 2'd2;

  localparam logic KIND_FILL  = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic             has_request;
    logic [CYL_W-1:0] cylinder;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]   served_cylinder;
    logic [TOTAL_W-1:0] total_movement;
    logic               none_left;
  } out_item_t;

  // Search token that walks down the row of cells.
  typedef struct packed {
    logic                  vld;
    logic                  a_found;
    logic [SLOT_IDX_W-1:0] a_idx;
    logic [CYL_W-1:0]      a_key;
    logic [CYL_W-1:0]      a_cyl;
    logic                  b_found;
    logic [SLOT_IDX_W-1:0] b_idx;
    logic [CYL_W-1:0]      b_key;
    logic [CYL_W-1:0]      b_cyl;
  } token_t;

  // Settings broadcast to every cell during a search.
  typedef struct packed {
    logic [1:0]            mode;
    logic [CYL_W-1:0]      head;
    logic [SLOT_IDX_W-1:0] fifo_ptr;
  } search_ctl_t;

  // Slot write broadcast to every cell.
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  valid;
    logic [CYL_W-1:0]      cyl;
  } slot_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [CYL_W-1:0] abs_diff(input logic [CYL_W-1:0] a,
                                                input logic [CYL_W-1:0] b);
    logic [CYL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

/* rtl/core/dsched_cell.sv */
// One request slot of the scheduler row with its stage of the search token.
module dsched_cell
  import dsched_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SLOT_IDX_W-1:0] cell_idx,
  input  search_ctl_t           ctl,
  input  slot_wr_t              wr,
  input  token_t                tok_i,
  output token_t                tok_o
);

  logic [CYL_W-1:0] slot_cyl_r;
  logic             slot_vld_r;
  logic             tok_vld_r;
  token_t           tok_r;
  token_t           tok_nxt;

  logic             is_sstf;
  logic             is_cscan;
  logic             is_fcfs;
  logic             a_elig;
  logic             b_elig;
  logic [CYL_W-1:0] a_key;
  logic [CYL_W-1:0] b_key;

  always_comb begin
    is_sstf  = (ctl.mode == MODE_SSTF);
    is_cscan = (ctl.mode == MODE_CSCAN);
    is_fcfs  = !is_sstf && !is_cscan;

    // Primary pick: ring order from the pointer, nearest, or nearest at or above the head.
    a_elig = slot_vld_r && (is_fcfs  ? (cell_idx >= ctl.fifo_ptr) :
                            is_cscan ? (slot_cyl_r >= ctl.head) : 1'b1);
    a_key  = is_fcfs ? '0 : abs_diff(slot_cyl_r, ctl.head);

    // Fallback pick: lowest index for FCFS, lowest cylinder for C-SCAN.
    b_elig = slot_vld_r && (is_fcfs || is_cscan);
    b_key  = is_fcfs ? '0 : slot_cyl_r;

    tok_nxt = tok_i;
    if (a_elig && (!tok_i.a_found || (a_key < tok_i.a_key))) begin
      tok_nxt.a_found = 1'b1;
      tok_nxt.a_idx   = cell_idx;
      tok_nxt.a_key   = a_key;
      tok_nxt.a_cyl   = slot_cyl_r;
    end
    if (b_elig && (!tok_i.b_found || (b_key < tok_i.b_key))) begin
      tok_nxt.b_found = 1'b1;
      tok_nxt.b_idx   = cell_idx;
      tok_nxt.b_key   = b_key;
      tok_nxt.b_cyl   = slot_cyl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
      tok_vld_r  <= 1'b0;
    end else begin
      tok_vld_r <= tok_nxt.vld;
      if (wr.en && (wr.idx == cell_idx)) begin
        slot_vld_r <= wr.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr.en && (wr.idx == cell_idx)) begin
      slot_cyl_r <= wr.valid ? wr.cyl : '0;
    end
  end

  // The valid bit comes from the reset register, the rest from the payload register.
  always_comb begin
    tok_o     = tok_r;
    tok_o.vld = tok_vld_r;
  end

endmodule

/* rtl/core/disk_request_scheduler.sv */
// Top level of the disk request scheduler: control, head state and the cell row.
//
//   Channel  Ports                                  Direction  Moves
//   in       in_valid, in_ready, in_data            to block   fill or serve item
//   out      out_valid, out_ready, out_data         from block one result per serve item
//   cfg      cfg_we, cfg_index, cfg_wdata           to block   register write, no wait
//
// A fill item is taken and writes the next slot until all slots are filled. A
// serve item first sends the search token SLOTS hops along the row of cells,
// one cell per cycle with the first in the accept cycle; then it picks and
// prices the move, and then it updates the state and loads the output register.
// The result and in_ready both come up in the cycle after that update. The
// finishing cycle waits while an earlier result has not been taken. Reset
// is synchronous and clears all slot valid bits, the pointers and the total.
module disk_request_scheduler
  import dsched_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CYL_W-1:0] cfg_wdata
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  // Configuration registers.
  logic [1:0]       mode_r;
  logic [CYL_W-1:0] max_cyl_r;

  // Scheduler state.
  state_t             state_r, state_nxt;
  logic [CYL_W-1:0]   head_r;
  logic [TOTAL_W-1:0] total_r;
  logic [IDXW-1:0]    fifo_ptr_r;
  logic [CNTW-1:0]    fill_ptr_r;
  in_item_t           req_r;

  // Pick registered at the end of the search.
  logic                sel_found_r, sel_found_nxt;
  logic [IDXW-1:0]     sel_idx_r, sel_idx_nxt;
  logic [CYL_W-1:0]    sel_cyl_r, sel_cyl_nxt;
  logic [TRAVEL_W-1:0] travel_r, travel_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;

  token_t      tok_chain [SLOTS+1];
  search_ctl_t ctl;
  slot_wr_t    wr;

  logic                in_acc;
  logic                fill_acc;
  logic                serve_acc;
  logic                out_free;
  logic                finish_go;
  logic                is_sstf;
  logic                is_cscan;
  logic [CYL_W-1:0]    wrap_up;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_sat;
  logic [IDXW-1:0]     fifo_next;
  token_t              tok_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign fill_acc  = in_acc && (in_data.kind == KIND_FILL);
  assign serve_acc = in_acc && (in_data.kind == KIND_SERVE);
  assign out_free  = !out_valid_r || out_ready;
  assign finish_go = (state_r == ST_FINISH) && out_free;
  assign tok_last  = tok_chain[SLOTS];

  assign is_sstf  = (mode_r == MODE_SSTF);
  assign is_cscan = (mode_r == MODE_CSCAN);

  // The search token enters the first cell in the cycle a serve item is taken.
  always_comb begin
    tok_chain[0]     = '0;
    tok_chain[0].vld = serve_acc;
  end

  assign ctl.mode     = mode_r;
  assign ctl.head     = head_r;
  assign ctl.fifo_ptr = SLOT_IDX_W'(fifo_ptr_r);

  // Slot writes come from a fill item or from the replacement at the end of a serve.
  always_comb begin
    wr = '0;
    if (fill_acc && (fill_ptr_r < CNTW'(SLOTS))) begin
      wr.en    = 1'b1;
      wr.idx   = SLOT_IDX_W'(fill_ptr_r);
      wr.valid = in_data.has_request;
      wr.cyl   = in_data.cylinder;
    end else if (finish_go && sel_found_r) begin
      wr.en    = 1'b1;
      wr.idx   = SLOT_IDX_W'(sel_idx_r);
      wr.valid = req_r.has_request;
      wr.cyl   = req_r.cylinder;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dsched_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_IDX_W'(g)),
      .ctl      (ctl),
      .wr       (wr),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1])
    );
  end

  // Turn the finished token into a pick and the head travel it costs. When
  // circular scan finds nothing at or above the head, the head sweeps up to
  // the last cylinder, returns to zero and then moves up to the lowest request.
  always_comb begin
    wrap_up = (max_cyl_r > head_r) ? (max_cyl_r - head_r) : '0;
    if (is_sstf) begin
      sel_found_nxt = tok_last.a_found;
      sel_idx_nxt   = tok_last.a_idx[IDXW-1:0];
      sel_cyl_nxt   = tok_last.a_cyl;
      travel_nxt    = TRAVEL_W'(abs_diff(tok_last.a_cyl, head_r));
    end else if (is_cscan && !tok_last.a_found) begin
      sel_found_nxt = tok_last.b_found;
      sel_idx_nxt   = tok_last.b_idx[IDXW-1:0];
      sel_cyl_nxt   = tok_last.b_cyl;
      travel_nxt    = TRAVEL_W'(wrap_up) + TRAVEL_W'(max_cyl_r) +
                      TRAVEL_W'(tok_last.b_cyl);
    end else begin
      // First come first served, or circular scan with a request at or above the head.
      sel_found_nxt = tok_last.a_found || tok_last.b_found;
      sel_idx_nxt   = tok_last.a_found ? tok_last.a_idx[IDXW-1:0]
                                       : tok_last.b_idx[IDXW-1:0];
      sel_cyl_nxt   = tok_last.a_found ? tok_last.a_cyl : tok_last.b_cyl;
      travel_nxt    = TRAVEL_W'(abs_diff(sel_cyl_nxt, head_r));
    end
  end

  // The running total saturates instead of wrapping.
  always_comb begin
    total_sum = {1'b0, total_r} + (TOTAL_W+1)'(travel_r);
    total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    fifo_next = (sel_idx_r == IDXW'(SLOTS - 1)) ? '0 : (sel_idx_r + 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (serve_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_last.vld) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_FCFS;
      max_cyl_r   <= MAX_CYL_RESET;
      head_r      <= '0;
      total_r     <= '0;
      fifo_ptr_r  <= '0;
      fill_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode_r    <= cfg_wdata[1:0];
          CFG_START: head_r    <= cfg_wdata;
          CFG_MAX:   max_cyl_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (fill_acc && (fill_ptr_r < CNTW'(SLOTS))) begin
        fill_ptr_r <= fill_ptr_r + 1'b1;
      end

      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (finish_go && sel_found_r) begin
        head_r  <= sel_cyl_r;
        total_r <= total_sat;
        if (!is_sstf && !is_cscan) begin
          fifo_ptr_r <= fifo_next;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (serve_acc) begin
      req_r <= in_data;
    end
    if ((state_r == ST_SCAN) && tok_last.vld) begin
      sel_found_r <= sel_found_nxt;
      sel_idx_r   <= sel_idx_nxt;
      sel_cyl_r   <= sel_cyl_nxt;
      travel_r    <= travel_nxt;
    end
    if (finish_go) begin
      out_data_r.served_cylinder <= sel_found_r ? sel_cyl_r : '0;
      out_data_r.total_movement  <= sel_found_r ? total_sat : total_r;
      out_data_r.none_left       <= !sel_found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
